// ===== design/spd_pkg.sv =====
// Shared types, constants and helpers for the stream pattern detector.
`timescale 1ns / 1ps

package spd_pkg;

  // Default table depth
  localparam int TableEntries = 16;

  // Field widths
  localparam int ProcW    = 22;
  localparam int MajorW   = 12;
  localparam int PartW    = 8;
  localparam int SectorW  = 48;
  localparam int SizeW    = 32;
  localparam int PatW     = 3;
  localparam int CountW   = 9;
  localparam int CredW    = 8;
  localparam int SecCntW  = SizeW - 9 + 1;  // size in sectors, rounded up

  localparam int InDataW  = 128;  // 122 bits of fields, padded to bytes
  localparam int OutDataW = 88;
  localparam int OutUserW = 4;

  // Confirmation count saturates here
  localparam logic [CountW-1:0] CountMax = 9'd256;

  // Pattern codes
  localparam logic [PatW-1:0] PatUnknown = 3'd0;
  localparam logic [PatW-1:0] PatSeqFwd  = 3'd1;
  localparam logic [PatW-1:0] PatSeqBwd  = 3'd2;
  localparam logic [PatW-1:0] PatStrFwd  = 3'd3;
  localparam logic [PatW-1:0] PatStrBwd  = 3'd4;

  // One stream entry as held in a cell
  typedef struct packed {
    logic [ProcW-1:0]   process_id;
    logic [MajorW-1:0]  device_major;
    logic [PartW-1:0]   device_partition;
    logic [PatW-1:0]    pattern;
    logic [CountW-1:0]  count;
    logic [SectorW-1:0] sector;
    logic [SizeW-1:0]   size;
  } entry_t;

  // Bytes to 512-byte sectors, rounded up
  function automatic logic [SecCntW-1:0] to_sectors(input logic [SizeW-1:0] bytes);
    logic [SecCntW-1:0] s;
    s = {1'b0, bytes[SizeW-1:9]};
    if (bytes[8:0] != 9'd0) begin
      s = s + 1'b1;
    end
    return s;
  endfunction

endpackage

// ===== design/spd_cell.sv =====
// One table cell: holds a stream entry, matches the key, hands its entry down.
`timescale 1ns / 1ps

module spd_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,       // take the neighbour's entry
  input  logic                          prev_valid,
  input  spd_pkg::entry_t               prev_entry,
  input  logic [spd_pkg::ProcW-1:0]     key_process,
  input  logic [spd_pkg::MajorW-1:0]    key_major,
  input  logic [spd_pkg::PartW-1:0]     key_partition,
  output logic                          valid,
  output spd_pkg::entry_t               entry,
  output logic                          hit
);

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
  end

  // Key match
  assign hit = valid && (entry.process_id == key_process)
             && (entry.device_major == key_major)
             && (entry.device_partition == key_partition);

endmodule

// ===== design/stream_pattern_detector_top.sv =====
// Top level: recency-ordered chain of stream cells with pattern classifier.
// Each item goes through a match state, then an update state that registers the result.
// The update state stalls while the result register holds a result not yet taken.
// A new item is taken in the update cycle whenever the result register is free.
// The cell chain is recency ordered; a hit or new entry moves to the front.
// Synchronous active-high reset empties the table and the result register.
`timescale 1ns / 1ps

module stream_pattern_detector_top #(
  parameter int TABLE_ENTRIES = spd_pkg::TableEntries
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // process_id, device_major, device_partition, start_sector, size_bytes, pad
  input  logic [spd_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // credibility, last_sector, last_size
  output logic [spd_pkg::OutDataW-1:0]  m_tdata,
  // pattern, details_valid
  output logic [spd_pkg::OutUserW-1:0]  m_tuser
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic       accept;
  logic       can_out;
  logic       do_update;

  // Registered input item
  logic [spd_pkg::ProcW-1:0]   in_process;
  logic [spd_pkg::MajorW-1:0]  in_major;
  logic [spd_pkg::PartW-1:0]   in_partition;
  logic [spd_pkg::SectorW-1:0] in_sector;
  logic [spd_pkg::SizeW-1:0]   in_size;

  // Cell chain signals
  logic                  cell_valid [TABLE_ENTRIES];
  spd_pkg::entry_t       cell_entry [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cell_hit;
  logic [TABLE_ENTRIES-1:0] shift_en;

  // Match stage registers
  logic [TABLE_ENTRIES-1:0] hit_q;
  logic                     any_hit_q;
  spd_pkg::entry_t          sel_q;
  spd_pkg::entry_t          sel_next;

  // Update stage logic
  spd_pkg::entry_t              head_entry;
  logic [spd_pkg::PatW-1:0]     cls;
  logic [spd_pkg::PatW-1:0]     pat_new;
  logic [spd_pkg::CountW-1:0]   cnt_new;
  logic [spd_pkg::SecCntW-1:0]  pz;
  logic [spd_pkg::SecCntW-1:0]  cz;
  logic [spd_pkg::SectorW-1:0]  diff_f;
  logic [spd_pkg::SectorW-1:0]  diff_b;
  logic [spd_pkg::CountW-1:0]   cnt_dec;

  assign can_out   = !m_tvalid || m_tready;
  assign do_update = (state == ST_UPDATE) && can_out;
  assign s_tready  = (state == ST_IDLE) || do_update;
  assign accept    = s_tvalid && s_tready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (accept) state <= ST_MATCH;
        ST_MATCH:  state <= ST_UPDATE;
        ST_UPDATE: if (do_update) state <= accept ? ST_MATCH : ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      in_process   <= s_tdata[21:0];
      in_major     <= s_tdata[33:22];
      in_partition <= s_tdata[41:34];
      in_sector    <= s_tdata[89:42];
      in_size      <= s_tdata[121:90];
    end
  end

  // Cell chain, front at index 0
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic            pv;
    spd_pkg::entry_t pe;
    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pe = head_entry;
    end else begin : g_body
      assign pv = cell_valid[i-1];
      assign pe = cell_entry[i-1];
    end
    // shift cells up to and including the hit; all on a miss
    assign shift_en[i] = !any_hit_q || (|(hit_q >> i));

    spd_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .shift         (do_update && shift_en[i]),
      .prev_valid    (pv),
      .prev_entry    (pe),
      .key_process   (in_process),
      .key_major     (in_major),
      .key_partition (in_partition),
      .valid         (cell_valid[i]),
      .entry         (cell_entry[i]),
      .hit           (cell_hit[i])
    );
  end

  // Select the hit entry (keys are unique, so an OR of masked entries)
  always_comb begin
    sel_next = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cell_hit[i]) begin
        sel_next = sel_next | cell_entry[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      hit_q     <= cell_hit;
      any_hit_q <= |cell_hit;
      sel_q     <= sel_next;
    end
  end

  // Classify previous request against this one
  assign pz     = spd_pkg::to_sectors(sel_q.size);
  assign cz     = spd_pkg::to_sectors(in_size);
  assign diff_f = in_sector - sel_q.sector;
  assign diff_b = sel_q.sector - in_sector;

  always_comb begin
    priority if (sel_q.sector < in_sector) begin
      priority if (diff_f <= {{(spd_pkg::SectorW-spd_pkg::SecCntW){1'b0}}, pz}) begin
        cls = spd_pkg::PatSeqFwd;
      end else if (pz == cz) begin
        cls = spd_pkg::PatStrFwd;
      end else begin
        cls = spd_pkg::PatUnknown;
      end
    end else if (sel_q.sector > in_sector) begin
      priority if (diff_b <= {{(spd_pkg::SectorW-spd_pkg::SecCntW){1'b0}}, cz}) begin
        cls = spd_pkg::PatSeqBwd;
      end else if (pz == cz) begin
        cls = spd_pkg::PatStrBwd;
      end else begin
        cls = spd_pkg::PatUnknown;
      end
    end else begin
      cls = spd_pkg::PatUnknown;
    end
  end

  // Run tracking
  always_comb begin
    priority if (!any_hit_q || sel_q.count == '0) begin
      pat_new = spd_pkg::PatUnknown;
    end else if (sel_q.count == spd_pkg::CountW'(1)) begin
      pat_new = cls;
    end else if (cls != sel_q.pattern) begin
      pat_new = spd_pkg::PatUnknown;
    end else begin
      pat_new = sel_q.pattern;
    end

    priority if (pat_new == spd_pkg::PatUnknown) begin
      cnt_new = spd_pkg::CountW'(1);
    end else if (sel_q.count < spd_pkg::CountMax) begin
      cnt_new = sel_q.count + 1'b1;
    end else begin
      cnt_new = sel_q.count;
    end
    cnt_dec = cnt_new - 1'b1;

    head_entry.process_id       = in_process;
    head_entry.device_major     = in_major;
    head_entry.device_partition = in_partition;
    head_entry.pattern          = pat_new;
    head_entry.count            = cnt_new;
    head_entry.sector           = in_sector;
    head_entry.size             = in_size;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      if (pat_new != spd_pkg::PatUnknown) begin
        m_tuser <= {1'b1, pat_new};
        m_tdata <= {in_size, in_sector, cnt_dec[spd_pkg::CredW-1:0]};
      end else begin
        m_tuser <= {1'b0, spd_pkg::PatUnknown};
        m_tdata <= '0;
      end
    end
  end

endmodule

// ===== design/spd_checker.sv =====
// Port-level checker for the stream pattern detector, bound to the top level.
`timescale 1ns / 1ps

module spd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [spd_pkg::OutDataW-1:0]  m_tdata,
  input logic [spd_pkg::OutUserW-1:0]  m_tuser
);

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Unknown pattern carries zero details
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[3] |-> m_tdata == '0 && m_tuser[2:0] == spd_pkg::PatUnknown)
    else $error("unknown result with non-zero details");

  // Valid details carry a known pattern code
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tuser[2:0] == spd_pkg::PatSeqFwd
      || m_tuser[2:0] == spd_pkg::PatSeqBwd || m_tuser[2:0] == spd_pkg::PatStrFwd
      || m_tuser[2:0] == spd_pkg::PatStrBwd)
    else $error("details valid with bad pattern");

  // Nothing is presented straight after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind stream_pattern_detector_top spd_checker u_spd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
